// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock clk, reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    typedef enum logic [1:0]
    {
        PART_A   = 2'd0,
        PART_B   = 2'd1,
        PART_MID = 2'd2
    } part_t;

endpackage

// File: hw/rtl/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Throughput: one beat per cycle unless the output stalls. The restoring
// divider (one quotient bit per stage) and the square root (one root bit
// per stage) are both pipelined.
// Reset clears only the stage valid bits; the pipe is empty after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_segment_distance
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH     = 16,
    parameter int U_FRACTION_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by_coord,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic        [COORD_WIDTH:0]   distance,
    output part_t                         nearest_part
);

    localparam int CW   = COORD_WIDTH;
    localparam int F    = U_FRACTION_BITS;
    localparam int DW   = CW + 1;          // coordinate differences
    localparam int PW   = 2 * DW;          // products, squared length
    localparam int DOTW = PW + 1;          // dot product / divider remainder
    localparam int MW   = F + 1 + DW;      // u * d product
    localparam int R    = CW + 1;          // root width
    localparam int RADW = 2 * R;           // radicand width
    localparam int REMS = R + 3;           // root remainder width

    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ---------------- stage a: differences
    logic                 a_v_reg;
    logic signed [DW-1:0] a_dx_reg, a_dy_reg, a_pax_reg, a_pay_reg, a_pbx_reg, a_pby_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (adv)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg  <= DW'(bx) - DW'(ax);
            a_dy_reg  <= DW'(by_coord) - DW'(ay);
            a_pax_reg <= DW'(px) - DW'(ax);
            a_pay_reg <= DW'(py) - DW'(ay);
            a_pbx_reg <= DW'(px) - DW'(bx);
            a_pby_reg <= DW'(py) - DW'(by_coord);
        end
    end

    // ---------------- stage b: products
    logic                 b_v_reg, b_degen_reg;
    logic signed [PW-1:0] b_d1_reg, b_d2_reg, b_l1_reg, b_l2_reg;
    logic signed [DW-1:0] b_dx_reg, b_dy_reg, b_pax_reg, b_pay_reg, b_pbx_reg, b_pby_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (adv)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_d1_reg    <= a_pax_reg * a_dx_reg;
            b_d2_reg    <= a_pay_reg * a_dy_reg;
            b_l1_reg    <= a_dx_reg * a_dx_reg;
            b_l2_reg    <= a_dy_reg * a_dy_reg;
            b_degen_reg <= (a_dx_reg == '0) && (a_dy_reg == '0);
            b_dx_reg    <= a_dx_reg;
            b_dy_reg    <= a_dy_reg;
            b_pax_reg   <= a_pax_reg;
            b_pay_reg   <= a_pay_reg;
            b_pbx_reg   <= a_pbx_reg;
            b_pby_reg   <= a_pby_reg;
        end
    end

    // ---------------- divider: index 0 is the classify stage
    logic                   d_v_reg   [0:F];
    logic [DOTW-1:0]        d_rem_reg [0:F];
    logic [PW-1:0]          d_len_reg [0:F];
    logic [F-1:0]           d_q_reg   [0:F];
    part_t                  d_part_reg[0:F];
    logic signed [DW-1:0]   d_dx_reg  [0:F];
    logic signed [DW-1:0]   d_dy_reg  [0:F];
    logic signed [DW-1:0]   d_pax_reg [0:F];
    logic signed [DW-1:0]   d_pay_reg [0:F];
    logic signed [DW-1:0]   d_pbx_reg [0:F];
    logic signed [DW-1:0]   d_pby_reg [0:F];

    logic signed [DOTW-1:0] dot_next;
    logic [PW-1:0]          len_next;
    part_t                  cls_next;

    always_comb
    begin
        dot_next = DOTW'(b_d1_reg) + DOTW'(b_d2_reg);
        len_next = $unsigned(b_l1_reg) + $unsigned(b_l2_reg);
        if (b_degen_reg || dot_next <= 0)
            cls_next = PART_A;
        else if (dot_next >= $signed({1'b0, len_next}))
            cls_next = PART_B;
        else
            cls_next = PART_MID;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg[0] <= 1'b0;
        else if (adv)
            d_v_reg[0] <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_rem_reg[0]  <= $unsigned(dot_next);
            d_len_reg[0]  <= len_next;
            d_q_reg[0]    <= '0;
            d_part_reg[0] <= cls_next;
            d_dx_reg[0]   <= b_dx_reg;
            d_dy_reg[0]   <= b_dy_reg;
            d_pax_reg[0]  <= b_pax_reg;
            d_pay_reg[0]  <= b_pay_reg;
            d_pbx_reg[0]  <= b_pbx_reg;
            d_pby_reg[0]  <= b_pby_reg;
        end
    end

    for (genvar k = 0; k < F; k++)
    begin : g_div
        logic [DOTW-1:0] rem2;
        logic            ge;

        assign rem2 = {d_rem_reg[k][DOTW-2:0], 1'b0};
        assign ge   = rem2 >= {1'b0, d_len_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_v_reg[k+1] <= 1'b0;
            else if (adv)
                d_v_reg[k+1] <= d_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_rem_reg[k+1]  <= ge ? rem2 - {1'b0, d_len_reg[k]} : rem2;
                d_q_reg[k+1]    <= F'({d_q_reg[k], ge});
                d_len_reg[k+1]  <= d_len_reg[k];
                d_part_reg[k+1] <= d_part_reg[k];
                d_dx_reg[k+1]   <= d_dx_reg[k];
                d_dy_reg[k+1]   <= d_dy_reg[k];
                d_pax_reg[k+1]  <= d_pax_reg[k];
                d_pay_reg[k+1]  <= d_pay_reg[k];
                d_pbx_reg[k+1]  <= d_pbx_reg[k];
                d_pby_reg[k+1]  <= d_pby_reg[k];
            end
        end
    end

    // ---------------- stage m: u * d
    logic                 m_v_reg;
    part_t                m_part_reg;
    logic signed [MW-1:0] m_px_reg, m_py_reg;
    logic signed [DW-1:0] m_pax_reg, m_pay_reg, m_pbx_reg, m_pby_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (adv)
            m_v_reg <= d_v_reg[F];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // interior case whose u floors to zero falls back to A
            if (d_part_reg[F] == PART_MID && d_q_reg[F] == '0)
                m_part_reg <= PART_A;
            else
                m_part_reg <= d_part_reg[F];
            m_px_reg  <= $signed({1'b0, d_q_reg[F]}) * d_dx_reg[F];
            m_py_reg  <= $signed({1'b0, d_q_reg[F]}) * d_dy_reg[F];
            m_pax_reg <= d_pax_reg[F];
            m_pay_reg <= d_pay_reg[F];
            m_pbx_reg <= d_pbx_reg[F];
            m_pby_reg <= d_pby_reg[F];
        end
    end

    // ---------------- stage f: error vector
    logic                 f_v_reg;
    part_t                f_part_reg;
    logic signed [DW-1:0] f_ex_reg, f_ey_reg;
    logic signed [DW-1:0] off_x, off_y;

    assign off_x = DW'(m_px_reg >>> F);
    assign off_y = DW'(m_py_reg >>> F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (adv)
            f_v_reg <= m_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_part_reg <= m_part_reg;
            case (m_part_reg)
                PART_A:
                begin
                    f_ex_reg <= m_pax_reg;
                    f_ey_reg <= m_pay_reg;
                end
                PART_B:
                begin
                    f_ex_reg <= m_pbx_reg;
                    f_ey_reg <= m_pby_reg;
                end
                default:
                begin
                    f_ex_reg <= m_pax_reg - off_x;
                    f_ey_reg <= m_pay_reg - off_y;
                end
            endcase
        end
    end

    // ---------------- stage g: squares
    logic            g_v_reg;
    part_t           g_part_reg;
    logic [PW-1:0]   g_sx_reg, g_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_v_reg <= 1'b0;
        else if (adv)
            g_v_reg <= f_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_part_reg <= f_part_reg;
            g_sx_reg   <= $unsigned(PW'(f_ex_reg) * PW'(f_ex_reg));
            g_sy_reg   <= $unsigned(PW'(f_ey_reg) * PW'(f_ey_reg));
        end
    end

    // ---------------- square root: index 0 holds the radicand
    logic              s_v_reg   [0:R];
    logic [RADW-1:0]   s_rad_reg [0:R];
    logic [REMS-1:0]   s_rem_reg [0:R];
    logic [R-1:0]      s_root_reg[0:R];
    part_t             s_part_reg[0:R];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_v_reg[0] <= 1'b0;
        else if (adv)
            s_v_reg[0] <= g_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_rad_reg[0]  <= RADW'(g_sx_reg) + RADW'(g_sy_reg);
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
            s_part_reg[0] <= g_part_reg;
        end
    end

    for (genvar i = 0; i < R; i++)
    begin : g_sqrt
        logic [REMS-1:0] cur;
        logic [REMS-1:0] trial;
        logic            ge;

        assign cur   = {s_rem_reg[i][REMS-3:0], s_rad_reg[i][RADW-1 -: 2]};
        assign trial = REMS'({s_root_reg[i], 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_v_reg[i+1] <= 1'b0;
            else if (adv)
                s_v_reg[i+1] <= s_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_rem_reg[i+1]  <= ge ? cur - trial : cur;
                s_root_reg[i+1] <= R'({s_root_reg[i], ge});
                s_rad_reg[i+1]  <= {s_rad_reg[i][RADW-3:0], 2'b00};
                s_part_reg[i+1] <= s_part_reg[i];
            end
        end
    end

    assign out_valid    = s_v_reg[R];
    assign distance     = s_root_reg[R];
    assign nearest_part = s_part_reg[R];

    // ---------------- checks
    `PSD_ASSERT_IMP(a_stall_map, 1'b1, in_stall == (out_valid && out_stall))
    `PSD_ASSERT_IMP(a_cls_mid, d_v_reg[0] && d_part_reg[0] == PART_MID,
                    d_rem_reg[0] < {1'b0, d_len_reg[0]})
    `PSD_ASSERT_IMP(a_div_rem, d_v_reg[F] && d_part_reg[F] == PART_MID,
                    d_rem_reg[F] < {1'b0, d_len_reg[F]})
    `PSD_ASSERT_IMP(a_sqrt_rem, s_v_reg[R], s_rem_reg[R] <= REMS'({s_root_reg[R], 1'b0}))
    `PSD_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid)

endmodule

// File: sim/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Watches the input and result channels, predicts the distance and nearest
// part of every accepted query beat and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module psd_checker
    import psd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] px,
    input  logic signed [15:0] py,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by_coord,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [16:0]        distance,
    input  part_t              nearest_part,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed
    {
        logic [16:0] dist_val;
        part_t       part;
    } seg_result_t;

    seg_result_t expected_q[$];

    function automatic longint floor_frac(longint v);
        // arithmetic shift floors toward minus infinity
        return v >>> 16;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
                r = r + (longint'(1) << b);
        end
        return r;
    endfunction

    function automatic longint span(longint x0, longint y0, longint x1, longint y1);
        return root_floor((x0 - x1) * (x0 - x1) + (y0 - y1) * (y0 - y1));
    endfunction

    function automatic seg_result_t nearest_on_segment(longint qx0, longint qy0,
        longint sx, longint sy, longint ex, longint ey);
        seg_result_t r;
        longint dx, dy, dot, len2, u;
        dx = ex - sx;
        dy = ey - sy;
        u = 0;
        if (dx == 0 && dy == 0)
        begin
            r.dist_val = 17'(span(qx0, qy0, sx, sy));
            r.part = PART_A;
        end
        else
        begin
            dot = (qx0 - sx) * dx + (qy0 - sy) * dy;
            len2 = dx * dx + dy * dy;
            if (dot > 0)
                u = (dot <<< 16) / len2;
            if (u == 0)
            begin
                r.dist_val = 17'(span(qx0, qy0, sx, sy));
                r.part = PART_A;
            end
            else if (u >= 65536)
            begin
                r.dist_val = 17'(span(qx0, qy0, ex, ey));
                r.part = PART_B;
            end
            else
            begin
                r.dist_val = 17'(span(qx0, qy0, sx + floor_frac(u * dx),
                    sy + floor_frac(u * dy)));
                r.part = PART_MID;
            end
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        seg_result_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(nearest_on_segment(px, py, ax, ay, bx, by_coord));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat: distance %0d part %0d",
                            distance, nearest_part);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.dist_val !== distance || e.part !== nearest_part)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected distance %0d part %0d, got %0d part %0d",
                                e.dist_val, e.part, distance, nearest_part);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/point_segment_distance_tb.sv
// ----------------------------------------------------------------------------
// point_segment_distance_tb
// Drives directed and random query beats with random gaps and output stalls;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_segment_distance_tb;
    import psd_pkg::*;

    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [15:0] px, py, ax, ay, bx, by_coord;
    logic [16:0] distance;
    part_t nearest_part;
    int fail_count, pending;
    int idle_cycles;
    bit timed_out;

    point_segment_distance DUT (.*);

    psd_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back beats; it drops only for a gap
    task automatic send(input int qx, qy, sx, sy, ex, ey);
        int g;
        g = gap_len();
        if ($urandom_range(0, 2) == 0)
            g = 0;
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        px <= 16'(qx); py <= 16'(qy); ax <= 16'(sx); ay <= 16'(sy);
        bx <= 16'(ex); by_coord <= 16'(ey);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // receiver stalls: bursty, with quiet stretches
    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 9) < 3)
                out_stall <= 1;
            else
                out_stall <= 0;
            if ($urandom_range(0, 199) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            if ($urandom_range(0, 99) == 0)
                repeat ($urandom_range(50, 200))
                begin
                    @(posedge clk);
                    out_stall <= 0;
                end
        end
    end

    initial
    begin
        idle_cycles = 0;
        timed_out = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL point_segment_distance");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] sx, sy, ex, ey;
        rst_n = 0;
        in_valid = 0;
        px = 0; py = 0; ax = 0; ay = 0; bx = 0; by_coord = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // degenerate segments, extremes, near-zero projection, beyond ends, interior
        send(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send(0, 0, 0, 0, 0, 0);
        send(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send(-5, 3, 0, 0, 100, 0);
        send(1, 50, 0, 0, 16'sh7fff, 0);
        send(0, 50, 0, 0, 16'sh7fff, 16'sh7fff);
        send(200, 7, 0, 0, 100, 0);
        send(100, -7, 0, 0, 100, 0);
        send(50, 9, 0, 0, 100, 0);
        send(33, -20, 0, 0, -100, 3);
        send(-33, 20, 10, 10, -90, -50);
        send(16'sh7fff, 0, 16'sh8000, 0, 16'sh7fff, 1);
        send(0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001);
        send(16'shffff, 16'shffff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);

        for (int i = 0; i < 1950; i++)
        begin
            sx = rand_coord(); sy = rand_coord();
            case ($urandom_range(0, 7))
                0: begin ex = sx; ey = sy; end
                1:
                begin
                    ex = sx + 16'($urandom_range(0, 6)) - 16'd3;
                    ey = sy + 16'($urandom_range(0, 6)) - 16'd3;
                end
                default: begin ex = rand_coord(); ey = rand_coord(); end
            endcase
            send(rand_coord(), rand_coord(), sx, sy, ex, ey);
            if (i == 900)
            begin
                in_valid <= 0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end

        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS point_segment_distance");
        else
            $display("FAIL point_segment_distance");
        $finish;
    end

endmodule
